// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_PPUSH  = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_FIND   = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] data_handle;
        logic [31:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_handle;
        logic [31:0] out_priority;
        logic [4:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic cmp;
        logic push;
        logic ppush;
        logic del;
    } t_cell_ctl;

endpackage

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue built from a chain of slot cells.
//
//   Channel   Valid        Ready        Payload
//   command   i_in_valid   o_in_ready   i_in_data  (spq_pkg::t_in)
//   result    o_out_valid  i_out_ready  o_out_data (spq_pkg::t_out)
//
// Every command passes through the transfer, a compare state in which all
// cells compare their entry with the key, and a shift state in which the cells
// shift as needed and the result is written to the output register. The shift state waits
// while the output register still holds a result that has not been taken. A new
// command is taken while a result waits. Reset empties the queue at once.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_out o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    spq_pkg::t_in        r_cmd;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    spq_pkg::t_out       r_out;
    spq_pkg::t_out       n_out;
    logic                r_out_valid;
    logic                n_out_valid;

    spq_pkg::t_entry     w_ent [CAPACITY];
    spq_pkg::t_entry     w_key;
    spq_pkg::t_entry     w_head_in;
    spq_pkg::t_entry     w_rd;
    spq_pkg::t_cell_ctl  w_ctl;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_tail;
    logic [CAPACITY-1:0] w_pre;
    logic [CAPACITY-1:0] w_ins;
    logic [CAPACITY-1:0] w_first;
    logic [CAPACITY-1:0] w_sel;
    logic [CW+4:0]       w_cnt_ext;
    logic                w_found;
    logic                w_full;
    logic                w_empty;
    logic                w_act;

    assign w_key     = '{handle: r_cmd.data_handle, prio: r_cmd.priority_req};
    assign w_head_in = '{handle: r_cmd.data_handle, prio: 32'd0};
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_found   = |w_eq;
    assign w_act     = (r_state == S_ACT) && (!r_out_valid || i_out_ready);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g]  = (CW'(g) < r_count);
        assign w_tail[g] = (CW'(g + 1) == r_count);

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (w_occ[g]),
            .i_key      (w_key),
            .i_ins_upto (w_ins[g]),
            .i_ins_prev ((g == 0) ? 1'b0 : w_ins[(g == 0) ? 0 : g - 1]),
            .i_hit_upto (w_pre[g]),
            .i_prev     ((g == 0) ? w_head_in : w_ent[(g == 0) ? 0 : g - 1]),
            .i_next     ((g == CAPACITY - 1) ? '0
                                             : w_ent[(g == CAPACITY - 1) ? g : g + 1]),
            .o_entry    (w_ent[g]),
            .o_eq       (w_eq[g]),
            .o_gt       (w_gt[g])
        );
    end

    always_comb begin
        w_pre = w_eq;
        for (int k = 0; k < IW; k++) begin
            w_pre = w_pre | (w_pre << (1 << k));
        end
    end

    // Cells at and after the first entry whose priority is not greater than the key shift.
    always_comb begin
        w_ins = ~w_gt;
        for (int k = 0; k < IW; k++) begin
            w_ins = w_ins | (w_ins << (1 << k));
        end
    end

    assign w_first = w_eq & ~(w_pre << 1);
    assign w_sel   = (r_cmd.command == spq_pkg::CMD_POP) ? w_tail : w_first;

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd = w_rd | (w_ent[i] & {$bits(spq_pkg::t_entry){w_sel[i]}});
        end
    end

    always_comb begin
        w_ctl.cmp   = (r_state == S_CMP);
        w_ctl.push  = w_act && (r_cmd.command == spq_pkg::CMD_PUSH) && !w_full;
        w_ctl.ppush = w_act && (r_cmd.command == spq_pkg::CMD_PPUSH) && !w_full;
        w_ctl.del   = w_act && (r_cmd.command == spq_pkg::CMD_REMOVE) && w_found;
    end

    assign w_cnt_ext = {5'd0, n_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                if (w_act) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out.status       = spq_pkg::ST_OK;
                    n_out.out_handle   = '0;
                    n_out.out_priority = '0;
                    case (r_cmd.command)
                        spq_pkg::CMD_PUSH, spq_pkg::CMD_PPUSH: begin
                            if (w_full) begin
                                n_out.status = spq_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        spq_pkg::CMD_POP: begin
                            if (w_empty) begin
                                n_out.status = spq_pkg::ST_EMPTY;
                            end else begin
                                n_count            = r_count - CW'(1);
                                n_out.out_handle   = w_rd.handle;
                                n_out.out_priority = w_rd.prio;
                            end
                        end
                        spq_pkg::CMD_FIND: begin
                            if (!w_found) begin
                                n_out.status = spq_pkg::ST_NOT_FOUND;
                            end else begin
                                n_out.out_handle   = w_rd.handle;
                                n_out.out_priority = w_rd.prio;
                            end
                        end
                        spq_pkg::CMD_REMOVE: begin
                            if (!w_found) begin
                                n_out.status = spq_pkg::ST_NOT_FOUND;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.entry_count = w_cnt_ext[4:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= i_in_data;
        end
    end

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/spq_cell.sv =====
// One slot of the queue: holds an entry, compares it with the key and shifts.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_key,
    input  logic               i_ins_upto,
    input  logic               i_ins_prev,
    input  logic               i_hit_upto,
    input  spq_pkg::t_entry    i_prev,
    input  spq_pkg::t_entry    i_next,
    output spq_pkg::t_entry    o_entry,
    output logic               o_eq,
    output logic               o_gt
);

    spq_pkg::t_entry r_entry;
    logic            r_eq;
    logic            r_gt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_eq <= i_occ && (r_entry.handle == i_key.handle);
            r_gt <= i_occ && (r_entry.prio > i_key.prio);
        end
        if (i_ctl.push) begin
            r_entry <= i_prev;
        end else if (i_ctl.ppush && i_ins_upto) begin
            r_entry <= i_ins_prev ? i_prev : i_key;
        end else if (i_ctl.del && i_hit_upto) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_eq    = r_eq;
    assign o_gt    = r_gt;

endmodule

// ===== src/spq_checker.sv =====
// Port-level checks for the sorted priority queue and their binding.
module spq_checker #(
    parameter int CAPACITY = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input spq_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input spq_pkg::t_out o_out_data
);

    // A command is taken only once the previous one has finished its shift.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("command transfer in back-to-back cycles");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != spq_pkg::ST_OK) |->
            (o_out_data.out_handle == '0 && o_out_data.out_priority == '0))
        else $error("failed command returned a nonzero entry");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == spq_pkg::ST_EMPTY) |->
            (o_out_data.entry_count == 5'd0))
        else $error("empty status with a nonzero count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((CAPACITY > 31) || (int'(o_out_data.entry_count) <= CAPACITY)))
        else $error("entry count above capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// ===== verif/sorted_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue, with directed and random commands.
module sorted_priority_queue_tb;

    localparam int CAPACITY = 16;
    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 150;

    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    spq_pkg::t_in in_data = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    spq_pkg::t_out out_data;

    logic [31:0] mirror_handle [CAPACITY];
    logic [31:0] mirror_prio [CAPACITY];
    int mirror_count = 0;
    spq_pkg::t_out pending_results [$];
    int error_count = 0;
    int result_index = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit filling = 1'b1;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic spq_pkg::t_out apply_command(input spq_pkg::t_in cmd);
        spq_pkg::t_out res;
        int pos;
        int hit;
        int i;
        res = '0;
        hit = 0;
        while (hit < mirror_count && mirror_handle[hit] != cmd.data_handle) hit++;
        case (cmd.command)
            spq_pkg::CMD_PUSH, spq_pkg::CMD_PPUSH: begin
                if (mirror_count >= CAPACITY) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    if (cmd.command == spq_pkg::CMD_PPUSH) begin
                        while (pos < mirror_count && mirror_prio[pos] > cmd.priority_req) pos++;
                    end
                    for (i = mirror_count; i > pos; i--) begin
                        mirror_handle[i] = mirror_handle[i - 1];
                        mirror_prio[i] = mirror_prio[i - 1];
                    end
                    mirror_handle[pos] = cmd.data_handle;
                    mirror_prio[pos] = (cmd.command == spq_pkg::CMD_PPUSH) ?
                                       cmd.priority_req : '0;
                    mirror_count++;
                end
            end
            spq_pkg::CMD_POP: begin
                if (mirror_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    mirror_count--;
                    res.out_handle = mirror_handle[mirror_count];
                    res.out_priority = mirror_prio[mirror_count];
                end
            end
            spq_pkg::CMD_FIND: begin
                if (hit >= mirror_count) begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    res.out_handle = mirror_handle[hit];
                    res.out_priority = mirror_prio[hit];
                end
            end
            spq_pkg::CMD_REMOVE: begin
                if (hit >= mirror_count) begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    for (i = hit; i + 1 < mirror_count; i++) begin
                        mirror_handle[i] = mirror_handle[i + 1];
                        mirror_prio[i] = mirror_prio[i + 1];
                    end
                    mirror_count--;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = 5'(mirror_count);
        return res;
    endfunction

    function automatic spq_pkg::t_in make_item(input logic [2:0] command,
                                               input logic [31:0] handle,
                                               input logic [31:0] prio);
        spq_pkg::t_in item;
        item.command = command;
        item.data_handle = handle;
        item.priority_req = prio;
        return item;
    endfunction

    function automatic spq_pkg::t_in random_command();
        spq_pkg::t_in item;
        int roll;
        item.data_handle = $urandom();
        item.priority_req = $urandom();
        if ($urandom_range(0, 99) < 4) filling = !filling;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            item.command = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
        end else if (roll < (filling ? 60 : 25)) begin
            item.command = ($urandom_range(0, 3) == 0) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_PPUSH;
            if (mirror_count > 0 && $urandom_range(0, 9) == 0) begin
                item.data_handle = mirror_handle[$urandom_range(0, mirror_count - 1)];
            end
        end else begin
            roll = $urandom_range(0, 9);
            item.command = (roll < 4) ? spq_pkg::CMD_POP :
                           ((roll < 7) ? spq_pkg::CMD_FIND : spq_pkg::CMD_REMOVE);
            if (mirror_count > 0 && $urandom_range(0, 3) != 0) begin
                item.data_handle = mirror_handle[$urandom_range(0, mirror_count - 1)];
            end
        end
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            item.priority_req = $urandom_range(0, 7);
        end else if (roll < 6 && mirror_count > 0) begin
            item.priority_req = mirror_prio[$urandom_range(0, mirror_count - 1)];
        end else if (roll == 6) begin
            item.priority_req = ($urandom_range(0, 1) == 0) ? '0 : '1;
        end
        return item;
    endfunction

    task automatic send_item(input spq_pkg::t_in item);
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(apply_command(item));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s is %h, expected %h", result_index, what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin : check_results
        spq_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command", out_data.out_handle, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_data.status != want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.out_handle != want.out_handle)
                    report_mismatch("out_handle", out_data.out_handle, want.out_handle);
                if (out_data.out_priority != want.out_priority)
                    report_mismatch("out_priority", out_data.out_priority, want.out_priority);
                if (out_data.entry_count != want.entry_count)
                    report_mismatch("entry_count", 32'(out_data.entry_count),
                                    32'(want.entry_count));
            end
            result_index++;
        end
    end

    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("sorted_priority_queue_tb: errors");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(make_item(spq_pkg::CMD_POP, '0, '0));
        send_item(make_item(spq_pkg::CMD_FIND, '0, '0));
        send_item(make_item(spq_pkg::CMD_REMOVE, '1, '1));
        send_item(make_item(spq_pkg::CMD_PUSH, '0, '1));
        send_item(make_item(spq_pkg::CMD_PPUSH, '1, '1));
        send_item(make_item(spq_pkg::CMD_PPUSH, 32'h0000_0011, '0));
        send_item(make_item(spq_pkg::CMD_PPUSH, 32'h0000_0022, 32'h8000_0000));
        send_item(make_item(spq_pkg::CMD_PPUSH, 32'h0000_0033, 32'h8000_0000));
        send_item(make_item(spq_pkg::CMD_PUSH, 32'h0000_0044, 32'h7FFF_FFFF));
        send_item(make_item(spq_pkg::CMD_PPUSH, 32'h0000_0011, 32'd5));
        send_item(make_item(spq_pkg::CMD_FIND, 32'h0000_0011, '0));
        send_item(make_item(spq_pkg::CMD_FIND, '1, '0));
        send_item(make_item(spq_pkg::CMD_FIND, 32'h1234_5678, '1));
        send_item(make_item(spq_pkg::CMD_REMOVE, 32'h0000_0011, '0));
        send_item(make_item(spq_pkg::CMD_REMOVE, 32'h0000_DEAD, '0));
        send_item(make_item(CMD_SPARE5, '1, '1));
        send_item(make_item(CMD_SPARE6, 32'h0000_0022, '0));
        send_item(make_item(CMD_SPARE7, '0, '1));
        send_item(make_item(spq_pkg::CMD_FIND, 32'h0000_0011, '0));
        repeat (7) send_item(make_item(spq_pkg::CMD_POP, '1, '1));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_item(random_command());
    endtask

    // The receiver holds off, which stalls the input; then the pushes overfill the queue.
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (CAPACITY + 3) begin
            send_item(make_item(spq_pkg::CMD_PPUSH, $urandom(), $urandom_range(0, 3)));
        end
        repeat (CAPACITY + 1) send_item(make_item(spq_pkg::CMD_POP, $urandom(), $urandom()));
    endtask

    task automatic finish_run();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("sorted_priority_queue_tb: clean");
        end else begin
            $display("sorted_priority_queue_tb: errors");
        end
        $finish;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(280, 0, 0);
        test_backpressure_fill();
        test_random_traffic(250, 82, 0);
        test_random_traffic(250, 0, 82);
        test_random_traffic(250, 36, 36);
        finish_run();
    end

endmodule
